### src/rida_pkg.sv
// Shared types and constants for the region intrusion dwell alarm.
// Used by the top level, the track table and the port checker.
`timescale 1ns / 1ps

package rida_pkg;

    // Number of track slots; a power of two, the slot is the low bits of the id.
    localparam int TRACK_SLOTS = 256;
    localparam int SLOT_W      = $clog2(TRACK_SLOTS);

    localparam int ID_W     = 8;
    localparam int CLASS_W  = 4;
    localparam int COORD_W  = 16;
    localparam int TIME_W   = 32;
    localparam int THRESH_W = 26;  // 65535 * 1000 fits in 26 bits
    localparam int MS_PER_S = 1000;

    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_SECONDS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_CLASS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMAN_CLASS   = 3'd6;

    localparam logic [COORD_W-1:0] DWELL_RESET = 16'd5;
    localparam logic [CLASS_W-1:0] FACE_RESET  = 4'd0;
    localparam logic [CLASS_W-1:0] HUMAN_RESET = 4'd1;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_ENTERED = 3'd1,
        EV_LEFT    = 3'd2,
        EV_ALARM   = 3'd3,
        EV_LOST    = 3'd4,
        EV_IGNORED = 3'd5
    } event_t;

    // One slot of the track table.
    typedef struct packed {
        logic              occupied;
        logic              alarmed;
        logic [TIME_W-1:0] entry_time;
    } track_entry_t;

    localparam int ENTRY_W = $bits(track_entry_t);

endpackage

### src/rida_table.sv
// Track table: a synchronous memory of track slots with a registered read.
// Depends on rida_pkg. Per-slot valid bits make reset clear the table at once,
// and a write on the same edge as a read of that slot is forwarded.
`timescale 1ns / 1ps

module rida_table
    import rida_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  track_entry_t      wr_data,
    output track_entry_t      rd_entry
);

    track_entry_t mem [TRACK_SLOTS];
    track_entry_t rd_data_reg;
    track_entry_t fwd_data_reg;
    logic [TRACK_SLOTS-1:0] valid_reg;
    logic rd_valid_reg;
    logic fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
                fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // A slot never written since reset reads as cleared.
    always_comb begin
        if (fwd_hit_reg) begin
            rd_entry = fwd_data_reg;
        end else if (rd_valid_reg) begin
            rd_entry = rd_data_reg;
        end else begin
            rd_entry = '0;
        end
    end

endmodule

### src/region_intrusion_dwell_alarm.sv
// Top level of the region intrusion dwell alarm: region test, dwell timing
// and event output. Depends on rida_pkg and rida_table.
//
//   Channel  Direction  Payload (lowest bit first)
//   s_       in         track id, class_code, track_lost, box_x/y/width/height, time_ms
//   m_       out        event_code, alarm, alarm_track, alarm_class
//   cfg_     in         register index, write data (no read-back)
//
// An accepted transaction reads its track slot on the accept edge; once the
// result register can take it, the slot is written back and the result
// register is loaded together. One transaction per cycle is sustained while
// the output side takes results. Back-to-back transactions on one track are
// served by forwarding inside the track table.
// Reset clears the whole table at once; no clearing pass is needed.
// The input stalls only when both the update stage and the result register
// hold transactions the output side has not taken.
`timescale 1ns / 1ps

module region_intrusion_dwell_alarm
    import rida_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // track id[7:0], class_code[11:8], track_lost[12], box_x[28:13],
    // box_y[44:29], box_width[60:45], box_height[76:61], time_ms[108:77], zero pad
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // event_code[2:0], alarm[3], alarm_track[11:4], alarm_class[15:12]
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [COORD_W-1:0]  region_x_reg, region_y_reg, region_w_reg, region_h_reg;
    logic [COORD_W-1:0]  dwell_reg;
    logic [CLASS_W-1:0]  face_reg, human_reg;
    logic [THRESH_W-1:0] thresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_x_reg <= '0;
            region_y_reg <= '0;
            region_w_reg <= '0;
            region_h_reg <= '0;
            dwell_reg    <= DWELL_RESET;
            face_reg     <= FACE_RESET;
            human_reg    <= HUMAN_RESET;
            thresh_reg   <= THRESH_W'(DWELL_RESET * MS_PER_S);
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_REGION_X:      region_x_reg <= cfg_data;
                    CFG_REGION_Y:      region_y_reg <= cfg_data;
                    CFG_REGION_WIDTH:  region_w_reg <= cfg_data;
                    CFG_REGION_HEIGHT: region_h_reg <= cfg_data;
                    CFG_DWELL_SECONDS: dwell_reg    <= cfg_data;
                    CFG_FACE_CLASS:    face_reg     <= cfg_data[CLASS_W-1:0];
                    CFG_HUMAN_CLASS:   human_reg    <= cfg_data[CLASS_W-1:0];
                    default: ;
                endcase
            end
            // The threshold is registered from the stored dwell setting.
            thresh_reg <= {{(THRESH_W-COORD_W){1'b0}}, dwell_reg} * THRESH_W'(MS_PER_S);
        end
    end

    // Input field unpacking.
    logic [ID_W-1:0]    in_tid;
    logic [CLASS_W-1:0] in_cls;
    logic               in_lost;
    logic [COORD_W-1:0] in_bx, in_by, in_bw, in_bh;
    logic [TIME_W-1:0]  in_time;

    assign in_tid  = s_tdata[7:0];
    assign in_cls  = s_tdata[11:8];
    assign in_lost = s_tdata[12];
    assign in_bx   = s_tdata[28:13];
    assign in_by   = s_tdata[44:29];
    assign in_bw   = s_tdata[60:45];
    assign in_bh   = s_tdata[76:61];
    assign in_time = s_tdata[108:77];

    // Centre test on the accept cycle; sums are one bit wider so they never wrap.
    logic [COORD_W:0] cx, cy, rx_end, ry_end;
    logic             in_region, class_ok;

    assign cx     = {1'b0, in_bx} + {2'b00, in_bw[COORD_W-1:1]};
    assign cy     = {1'b0, in_by} + {2'b00, in_bh[COORD_W-1:1]};
    assign rx_end = {1'b0, region_x_reg} + {1'b0, region_w_reg};
    assign ry_end = {1'b0, region_y_reg} + {1'b0, region_h_reg};
    assign in_region = (cx >= {1'b0, region_x_reg}) && (cx < rx_end) &&
                       (cy >= {1'b0, region_y_reg}) && (cy < ry_end);
    assign class_ok  = (in_cls == face_reg) || (in_cls == human_reg);

    // Update stage and result register handshake.
    logic               p1_valid_reg;
    logic [ID_W-1:0]    p1_tid_reg;
    logic [CLASS_W-1:0] p1_cls_reg;
    logic               p1_lost_reg, p1_in_reg, p1_cls_ok_reg;
    logic [TIME_W-1:0]  p1_time_reg;
    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic               out_free, p1_adv, s_accept;

    assign out_free = !m_valid_reg || m_tready;
    assign p1_adv   = p1_valid_reg && out_free;
    assign s_tready = !p1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_tid_reg    <= in_tid;
            p1_cls_reg    <= in_cls;
            p1_lost_reg   <= in_lost;
            p1_in_reg     <= in_region;
            p1_cls_ok_reg <= class_ok;
            p1_time_reg   <= in_time;
        end
    end

    // Slot update and event decision.
    track_entry_t      cur_entry, new_entry;
    event_t            ev;
    logic [TIME_W-1:0] elapsed;
    logic              dwell_done, wr_en;

    assign elapsed    = p1_time_reg - cur_entry.entry_time;
    assign dwell_done = elapsed >= {{(TIME_W-THRESH_W){1'b0}}, thresh_reg};
    assign wr_en      = p1_adv && p1_cls_ok_reg;

    always_comb begin
        new_entry = cur_entry;
        ev        = EV_NONE;
        if (!p1_cls_ok_reg) begin
            ev = EV_IGNORED;
        end else if (p1_lost_reg) begin
            new_entry = '0;
            ev        = EV_LOST;
        end else if (p1_in_reg && !cur_entry.occupied) begin
            new_entry.occupied   = 1'b1;
            new_entry.entry_time = p1_time_reg;
            ev                   = EV_ENTERED;
        end else if (!p1_in_reg && cur_entry.occupied) begin
            new_entry = '0;
            ev        = EV_LEFT;
        end else if (p1_in_reg && dwell_done && !cur_entry.alarmed) begin
            new_entry.alarmed = 1'b1;
            ev                = EV_ALARM;
        end
    end

    rida_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rd_addr  (SLOT_W'(in_tid)),
        .wr_en    (wr_en),
        .wr_addr  (SLOT_W'(p1_tid_reg)),
        .wr_data  (new_entry),
        .rd_entry (cur_entry)
    );

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            m_data_reg <= {p1_cls_reg, p1_tid_reg, (ev == EV_ALARM), ev};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### src/rida_checker.sv
// Port-level checker for the region intrusion dwell alarm, bound to the top level.
// Depends on rida_pkg for the event codes.
`timescale 1ns / 1ps

module rida_checker
    import rida_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tvalid,
    input logic                m_tready
);

    // A result held back by the output side keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The alarm flag goes with the alarm event and no other.
    a_alarm_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3] == (m_tdata[2:0] == EV_ALARM)))
        else $error("alarm flag does not match event code");

    // Only defined event codes are delivered.
    a_event_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= EV_IGNORED))
        else $error("undefined event code");

    // No result can appear in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The block accepts input whenever its output side is taking results.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

endmodule

bind region_intrusion_dwell_alarm rida_checker u_rida_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

### tb/sv/tb.sv
// Self-checking testbench for the region intrusion dwell alarm.
// Depends on rida_pkg and region_intrusion_dwell_alarm; it drives both stream channels
// and the register port, and checks each event against its own track table.
`timescale 1ns / 1ps

module tb;
    import rida_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 125;
    localparam int POOL_SIZE      = 6;
    // Index past the last register; writes to it must leave every setting alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic [ID_W-1:0]    track_num;
        logic [CLASS_W-1:0] class_code;
        logic               lost;
        logic [COORD_W-1:0] box_x;
        logic [COORD_W-1:0] box_y;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
        logic [TIME_W-1:0]  time_ms;
    } detection_t;

    typedef struct {
        event_t             ev;
        logic               alarm;
        logic [ID_W-1:0]    track;
        logic [CLASS_W-1:0] cls;
    } intrusion_event_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Expected copy of the settings and of the per-track table.
    logic [COORD_W-1:0] region_x   = '0;
    logic [COORD_W-1:0] region_y   = '0;
    logic [COORD_W-1:0] region_w   = '0;
    logic [COORD_W-1:0] region_h   = '0;
    logic [COORD_W-1:0] dwell_s    = DWELL_RESET;
    logic [CLASS_W-1:0] face_code  = FACE_RESET;
    logic [CLASS_W-1:0] human_code = HUMAN_RESET;
    logic               slot_inside  [TRACK_SLOTS] = '{default: 1'b0};
    logic               slot_alarmed [TRACK_SLOTS] = '{default: 1'b0};
    logic [TIME_W-1:0]  slot_entry   [TRACK_SLOTS] = '{default: '0};

    intrusion_event_t pending_events[$];
    int mismatch_count = 0;
    int idle_cycles    = 0;

    // Stimulus bookkeeping.
    logic [TIME_W-1:0] track_clock [TRACK_SLOTS];
    logic [ID_W-1:0]   track_pool [POOL_SIZE];
    logic              gaps_on     = 1'b1;
    int                burst_left  = 0;
    int                hold_cycles = 0;
    int                rx_mode     = 0;
    int                mode_left   = 0;

    region_intrusion_dwell_alarm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Works out the event for one detection and updates the expected track table.
    function automatic intrusion_event_t next_intrusion_event(input detection_t d);
        intrusion_event_t r;
        logic [COORD_W:0]  cx;
        logic [COORD_W:0]  cy;
        logic              now_in;
        logic [TIME_W-1:0] elapsed;
        r.ev    = EV_NONE;
        r.track = d.track_num;
        r.cls   = d.class_code;
        if (d.class_code != face_code && d.class_code != human_code) begin
            r.ev = EV_IGNORED;
        end else if (d.lost) begin
            slot_inside[d.track_num]  = 1'b0;
            slot_entry[d.track_num]   = '0;
            slot_alarmed[d.track_num] = 1'b0;
            r.ev = EV_LOST;
        end else begin
            cx = {1'b0, d.box_x} + {2'b00, d.box_width[COORD_W-1:1]};
            cy = {1'b0, d.box_y} + {2'b00, d.box_height[COORD_W-1:1]};
            now_in = cx >= {1'b0, region_x} && cx < {1'b0, region_x} + {1'b0, region_w} &&
                     cy >= {1'b0, region_y} && cy < {1'b0, region_y} + {1'b0, region_h};
            if (now_in && !slot_inside[d.track_num]) begin
                slot_inside[d.track_num] = 1'b1;
                slot_entry[d.track_num]  = d.time_ms;
                r.ev = EV_ENTERED;
            end else if (!now_in && slot_inside[d.track_num]) begin
                slot_inside[d.track_num]  = 1'b0;
                slot_entry[d.track_num]   = '0;
                slot_alarmed[d.track_num] = 1'b0;
                r.ev = EV_LEFT;
            end else if (now_in) begin
                elapsed = d.time_ms - slot_entry[d.track_num];
                if (elapsed >= dwell_s * 32'd1000 && !slot_alarmed[d.track_num]) begin
                    slot_alarmed[d.track_num] = 1'b1;
                    r.ev = EV_ALARM;
                end
            end
        end
        r.alarm = (r.ev == EV_ALARM);
        return r;
    endfunction

    function automatic detection_t make_det(input logic [ID_W-1:0] tid,
                                            input logic [CLASS_W-1:0] cls,
                                            input logic lost,
                                            input logic [COORD_W-1:0] bx, by, bw, bh,
                                            input logic [TIME_W-1:0] t);
        detection_t d;
        d.track_num  = tid;
        d.class_code = cls;
        d.lost       = lost;
        d.box_x      = bx;
        d.box_y      = by;
        d.box_width  = bw;
        d.box_height = bh;
        d.time_ms    = t;
        return d;
    endfunction

    // Returns {origin, size} along one axis, with the box centre aimed inside
    // the region span, just around its edges, or anywhere along the axis.
    function automatic logic [31:0] place_axis(input logic [COORD_W-1:0] base,
                                               input logic [COORD_W-1:0] span,
                                               input logic want_in);
        int target;
        int size;
        int org;
        size = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 255);
        if (want_in && span != 0) begin
            target = int'(base) + int'($urandom_range(0, span - 1));
        end else begin
            case ($urandom_range(0, 2))
                0: target = int'(base) - int'($urandom_range(1, 8));
                1: target = int'(base) + int'(span) + int'($urandom_range(0, 8));
                default: target = $urandom_range(0, 98302);
            endcase
        end
        org = target - size / 2;
        if (org < 0) begin
            org = 0;
        end else if (org > 65535) begin
            org = 65535;
        end
        return {org[15:0], size[15:0]};
    endfunction

    // Mostly plausible tracks with advancing timestamps; one in ten is pure noise.
    function automatic detection_t random_detection();
        detection_t    d;
        logic [31:0]   xa;
        logic [31:0]   ya;
        logic          want_in;
        int            pick;
        d.track_num = track_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 9) == 0) begin
            d.track_num  = ID_W'($urandom);
            d.class_code = CLASS_W'($urandom);
            d.lost       = 1'($urandom);
            d.box_x      = COORD_W'($urandom);
            d.box_y      = COORD_W'($urandom);
            d.box_width  = COORD_W'($urandom);
            d.box_height = COORD_W'($urandom);
            d.time_ms    = $urandom;
        end else begin
            pick = $urandom_range(0, 19);
            d.class_code = (pick < 9) ? face_code : (pick < 18) ? human_code : 4'($urandom);
            d.lost  = ($urandom_range(0, 24) == 0);
            want_in = ($urandom_range(0, 9) < 6);
            xa = place_axis(region_x, region_w, want_in);
            ya = place_axis(region_y, region_h, want_in);
            {d.box_x, d.box_width}  = xa;
            {d.box_y, d.box_height} = ya;
            track_clock[d.track_num] += $urandom_range(0, 1500);
            d.time_ms = track_clock[d.track_num];
        end
        return d;
    endfunction

    // Offers one detection, waits for the transaction and records its expected event.
    task automatic send_detection(input detection_t d);
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        s_tdata  <= {3'b000, d.time_ms, d.box_height, d.box_width, d.box_y, d.box_x,
                     d.lost, d.class_code, d.track_num};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_events.insert(pending_events.size(), next_intrusion_event(d));
    endtask

    // Waits on the clock before testing the queue, so the valid never toggles twice in a step.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_events.size() != 0);
    endtask

    task automatic set_config(input logic [COORD_W-1:0] rx, ry, rw, rh, dwell,
                              input logic [CLASS_W-1:0] face, human);
        logic [CFG_IDX_W-1:0] idx [8];
        logic [CFG_W-1:0]     val [8];
        wait_drained();
        repeat (4) @(posedge aclk);
        idx = '{CFG_REGION_X, CFG_REGION_Y, CFG_REGION_WIDTH, CFG_REGION_HEIGHT,
                CFG_DWELL_SECONDS, CFG_FACE_CLASS, CFG_HUMAN_CLASS, CFG_UNUSED};
        val = '{rx, ry, rw, rh, dwell, {12'h000, face}, {12'h000, human}, 16'($urandom)};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        region_x   = rx;
        region_y   = ry;
        region_w   = rw;
        region_h   = rh;
        dwell_s    = dwell;
        face_code  = face;
        human_code = human;
    endtask

    task automatic test_reset_defaults();
        // Region is empty after reset, so a human class stays outside.
        send_detection(make_det(8'd0, 4'd1, 1'b0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'd0));
        send_detection(make_det(8'd255, 4'd0, 1'b1, 16'd5, 16'd5, 16'd5, 16'd5, 32'd1));
        // Class outside both codes is ignored even when the track is lost.
        send_detection(make_det(8'd7, 4'd15, 1'b1, 16'd5, 16'd5, 16'd5, 16'd5, 32'd2));
    endtask

    task automatic test_region_edges();
        set_config(16'd100, 16'd200, 16'd50, 16'd40, 16'd0, 4'd15, 4'd3);
        // Entry on the left and top edges; zero dwell alarms on the next item only.
        send_detection(make_det(8'd1, 4'd15, 1'b0, 16'd100, 16'd200, 16'd0, 16'd1, 32'd0));
        send_detection(make_det(8'd1, 4'd3, 1'b0, 16'd100, 16'd200, 16'd0, 16'd1, 32'd0));
        send_detection(make_det(8'd1, 4'd15, 1'b0, 16'd120, 16'd210, 16'd4, 16'd4, 32'd5));
        send_detection(make_det(8'd1, 4'd3, 1'b0, 16'd148, 16'd238, 16'd3, 16'd3, 32'd6));
        // Right and bottom edges are exclusive.
        send_detection(make_det(8'd1, 4'd15, 1'b0, 16'd150, 16'd220, 16'd1, 16'd0, 32'd7));
        send_detection(make_det(8'd2, 4'd15, 1'b0, 16'd120, 16'd240, 16'd0, 16'd0, 32'd8));
        send_detection(make_det(8'd2, 4'd15, 1'b0, 16'd99, 16'd220, 16'd0, 16'd0, 32'd9));
        send_detection(make_det(8'd2, 4'd3, 1'b0, 16'd120, 16'd199, 16'd0, 16'd1, 32'd10));
        send_detection(make_det(8'd2, 4'd3, 1'b0, 16'd110, 16'd205, 16'd20, 16'd20, 32'd11));
        send_detection(make_det(8'd2, 4'd3, 1'b1, 16'd110, 16'd205, 16'd20, 16'd20, 32'd12));
        send_detection(make_det(8'd2, 4'd5, 1'b1, 16'd110, 16'd205, 16'd20, 16'd20, 32'd13));
    endtask

    task automatic test_wide_region_dwell();
        logic [TIME_W-1:0] t0;
        t0 = 32'hFFFF_F000;
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0, 4'd15);
        // Centre sums run past 16 bits; elapsed time wraps past zero.
        send_detection(make_det(8'd255, 4'd0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, t0));
        send_detection(make_det(8'd255, 4'd15, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                t0 + 32'd65534999));
        send_detection(make_det(8'd255, 4'd15, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                t0 + 32'd65535000));
        send_detection(make_det(8'd0, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0));
        send_detection(make_det(8'd255, 4'd15, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF));
    endtask

    task automatic test_random_traffic();
        logic [CLASS_W-1:0] shared_code;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_config(16'd0, 16'd0, 16'($urandom_range(100, 400)),
                              16'($urandom_range(100, 400)), 16'($urandom_range(0, 3)),
                              4'($urandom), 4'($urandom));
                1: set_config(16'($urandom_range(0, 60000)), 16'($urandom_range(0, 60000)),
                              16'($urandom_range(20, 300)), 16'($urandom_range(20, 300)),
                              16'($urandom_range(0, 3)), 4'($urandom), 4'($urandom));
                2: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'($urandom_range(0, 2)), 4'($urandom), 4'($urandom));
                3: set_config(16'($urandom), 16'($urandom), 16'($urandom_range(20, 300)),
                              16'd0, 16'd1, 4'($urandom), 4'($urandom));
                4: begin
                    // Face and human share one code.
                    shared_code = CLASS_W'($urandom);
                    set_config(16'($urandom_range(0, 60000)), 16'($urandom_range(0, 60000)),
                               16'($urandom_range(20, 300)), 16'($urandom_range(20, 300)),
                               16'd0, shared_code, shared_code);
                end
                default: set_config(16'($urandom_range(0, 60000)),
                                    16'($urandom_range(0, 60000)),
                                    16'($urandom_range(20, 300)), 16'($urandom_range(20, 300)),
                                    16'hFFFF, 4'($urandom), 4'($urandom));
            endcase
            for (int k = 0; k < POOL_SIZE; k++) begin
                track_pool[k] = ID_W'($urandom);
            end
            gaps_on = (phase != 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Long output stall while input keeps coming, so the block backs up.
                if (phase == 1 && n == 30) begin
                    hold_cycles = 300;
                end
                if (phase == 2 && n == 60) begin
                    wait_drained();
                end
                send_detection(random_detection());
            end
        end
    endtask

    // Output side: stall pattern that changes mode now and then.
    always @(posedge aclk) begin : result_ready
        logic ready_next;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_cycles > 0) begin
                hold_cycles--;
                ready_next = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (rx_mode)
                    0: ready_next = 1'b1;
                    1: ready_next = $urandom_range(0, 1);
                    default: ready_next = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_tready <= ready_next;
        end
    end

    always @(posedge aclk) begin : event_check
        intrusion_event_t want;
        event_t           got_ev;
        if (aresetn && m_tvalid && m_tready) begin
            got_ev = event_t'(m_tdata[2:0]);
            if (pending_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: unexpected result ev=%0d alarm=%0d track=%0d class=%0d",
                             $realtime, m_tdata[2:0], m_tdata[3], m_tdata[11:4], m_tdata[15:12]);
                end
            end else begin
                want = pending_events.pop_front();
                if (got_ev !== want.ev || m_tdata[3] !== want.alarm ||
                    m_tdata[11:4] !== want.track || m_tdata[15:12] !== want.cls) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"%0t: mismatch expected ev=%0d alarm=%0d track=%0d ",
                                  "class=%0d, got ev=%0d alarm=%0d track=%0d class=%0d"},
                                 $realtime, want.ev, want.alarm, want.track, want.cls,
                                 m_tdata[2:0], m_tdata[3], m_tdata[11:4], m_tdata[15:12]);
                    end
                end
            end
        end
    end

    // Ends the run if no transaction of any kind moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TRACK_SLOTS; i++) begin
            // Half the tracks start close to the timestamp wrap.
            track_clock[i] = (i % 2) ? 32'($urandom) : 32'hFFFF_F000 + $urandom_range(0, 2000);
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_region_edges();
        test_wide_region_dwell();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_events.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
src/rida_pkg.sv
src/rida_table.sv
src/region_intrusion_dwell_alarm.sv
src/rida_checker.sv
tb/sv/tb.sv
